// ----- sv/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the time-of-day clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/bcdtod_pkg.sv -----
// Types, constants and BCD increment functions of the time-of-day clock.
package bcdtod_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_START = 2'd2,
        OP_STOP  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_ALARM_HOUR   = 2'd0,
        CFG_ALARM_MINUTE = 2'd1,
        CFG_ALARM_SECOND = 2'd2,
        CFG_ALARM_TENTH  = 2'd3
    } t_cfg_idx;

    localparam logic [3:0] TENTH_LAST  = 4'h9;
    localparam logic [6:0] SEXA_LAST   = 7'h59;
    localparam logic [4:0] HOUR_ONE    = 5'h01;
    localparam logic [4:0] HOUR_NINE   = 5'h09;
    localparam logic [4:0] HOUR_TEN    = 5'h10;
    localparam logic [4:0] HOUR_ELEVEN = 5'h11;
    localparam logic [4:0] HOUR_TWELVE = 5'h12;
    localparam logic [7:0] HOUR_RESET  = 8'h01;

    typedef struct packed {
        logic [7:0] hour;
        logic [6:0] minute;
        logic [6:0] second;
        logic [3:0] tenth;
    } t_tod;

    typedef struct packed {
        t_tod tod;
        logic halted;
        logic match_seen;
    } t_state;

    typedef struct packed {
        t_tod tod;
        logic alarm_irq;
        logic running;
    } t_result;

    // A digit of 9 or 15 wraps to 0; everything else counts up.
    function automatic logic [3:0] digit_next(input logic [3:0] d);
        if (d == 4'h9 || d == 4'hF) begin
            return 4'h0;
        end
        return d + 4'h1;
    endfunction

    // Two-digit BCD increment on a 7-bit value; the high digit wraps in 3 bits.
    function automatic logic [6:0] bcd7_next(input logic [6:0] x);
        if (x[3:0] == 4'h9 || x[3:0] == 4'hF) begin
            return {x[6:4] + 3'd1, 4'h0};
        end
        return {x[6:4], x[3:0] + 4'd1};
    endfunction

    // 12-hour rollover; only the PM bit and the 5-bit hour survive.
    function automatic logic [7:0] hour_next(input logic [7:0] h);
        logic [4:0] hr;
        logic [4:0] nhr;
        logic       pm;
        hr = h[4:0];
        pm = h[7] ^ (hr == HOUR_ELEVEN);
        if (hr == HOUR_TWELVE) begin
            nhr = HOUR_ONE;
        end else if (hr == HOUR_NINE) begin
            nhr = HOUR_TEN;
        end else begin
            nhr = {hr[4], hr[3:0] + 4'd1};
        end
        return {pm, 2'b00, nhr};
    endfunction

    // Advance the time by one tenth of a second with carries.
    function automatic t_tod tod_advance(input t_tod t);
        t_tod r;
        r = t;
        if (t.tenth != TENTH_LAST) begin
            r.tenth = digit_next(t.tenth);
        end else begin
            r.tenth = 4'h0;
            if (t.second != SEXA_LAST) begin
                r.second = bcd7_next(t.second);
            end else begin
                r.second = 7'h00;
                if (t.minute != SEXA_LAST) begin
                    r.minute = bcd7_next(t.minute);
                end else begin
                    r.minute = 7'h00;
                    r.hour   = hour_next(t.hour);
                end
            end
        end
        return r;
    endfunction

endpackage

// ----- sv/bcdtod_ifs.sv -----
// Channel interfaces of the time-of-day clock: input, result and configuration.
interface bcdtod_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] load_hour;
    logic [6:0] load_minute;
    logic [6:0] load_second;
    logic [3:0] load_tenth;

    modport source (output valid, operation, load_hour, load_minute, load_second,
                    load_tenth, input ready);
    modport sink (input valid, operation, load_hour, load_minute, load_second,
                  load_tenth, output ready);
endinterface

interface bcdtod_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] time_hour;
    logic [6:0] time_minute;
    logic [6:0] time_second;
    logic [3:0] time_tenth;
    logic       alarm_irq;
    logic       running;

    modport source (output valid, time_hour, time_minute, time_second, time_tenth,
                    alarm_irq, running, input ready);
    modport sink (input valid, time_hour, time_minute, time_second, time_tenth,
                  alarm_irq, running, output ready);
endinterface

interface bcdtod_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/bcdtod_step.sv -----
// Next-state and result logic for one input transaction of the clock.
module bcdtod_step (
    input  bcdtod_pkg::t_state  i_state,
    input  logic [1:0]          i_op,
    input  bcdtod_pkg::t_tod    i_load,
    input  bcdtod_pkg::t_tod    i_alarm,
    output bcdtod_pkg::t_state  o_state,
    output bcdtod_pkg::t_result o_result
);
    import bcdtod_pkg::*;

    t_tod w_adv;
    logic w_eq;
    logic w_irq;

    assign w_adv = tod_advance(i_state.tod);
    assign w_eq  = (w_adv == i_alarm);

    always_comb begin
        o_state = i_state;
        w_irq   = 1'b0;
        case (t_op'(i_op))
            OP_TICK: begin
                if (!i_state.halted) begin
                    o_state.tod        = w_adv;
                    o_state.match_seen = w_eq;
                    w_irq              = w_eq && !i_state.match_seen;
                end
            end
            OP_LOAD:  o_state.tod    = i_load;
            OP_START: o_state.halted = 1'b0;
            OP_STOP:  o_state.halted = 1'b1;
            default:  o_state = i_state;
        endcase
    end

    assign o_result.tod       = o_state.tod;
    assign o_result.alarm_irq = w_irq;
    assign o_result.running   = !o_state.halted;

endmodule

// ----- sv/bcdtod_outq.sv -----
// Result register with a skid stage that drives the result channel.
module bcdtod_outq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  bcdtod_pkg::t_result  i_data,
    output logic                 o_ready,
    bcdtod_out_if.source         o_out
);
    import bcdtod_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out_data;
    t_result r_skid_data;
    logic    w_pop;

    assign w_pop   = r_out_valid && o_out.ready;
    assign o_ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_pop) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (i_push) begin
                r_out_data <= i_data;
            end
        end else if (i_push) begin
            r_skid_data <= i_data;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.time_hour   = r_out_data.tod.hour;
    assign o_out.time_minute = r_out_data.tod.minute;
    assign o_out.time_second = r_out_data.tod.second;
    assign o_out.time_tenth  = r_out_data.tod.tenth;
    assign o_out.alarm_irq   = r_out_data.alarm_irq;
    assign o_out.running     = r_out_data.running;

endmodule

// ----- sv/bcd_time_of_day_clock_alarm.sv -----
// BCD time-of-day clock with 12-hour hours, PM flag and a tenth-exact alarm.
//
// Each input transaction on i_in is a tick (one tenth of a second has gone by),
// a time load, a start or a stop. Every input transaction yields exactly one
// result transaction on o_out with the time after the step, the running flag
// and alarm_irq, which is high only on the running tick where the time begins
// to match the alarm registers.
// The alarm registers are written through i_cfg, index 0 hour, 1 minute,
// 2 second, 3 tenth; i_cfg is always ready and each write is registered.
// Each taken input's result goes to the result register, or to the skid stage
// while that register is full and unread. One transaction is taken per cycle
// while i_in.ready is high; the BCD carry chain and the alarm compare sit between
// the state registers and the result register. When the receiver stalls, a skid
// stage takes one more result; i_in.ready drops only while both stages are full.
// Synchronous reset (i_rst_n low) stops the clock at 01:00:00.0 AM, clears the
// alarm registers and the match history, and empties the result stages.
`include "assert_macros.svh"

module bcd_time_of_day_clock_alarm (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bcdtod_cfg_if.sink    i_cfg,
    bcdtod_in_if.sink     i_in,
    bcdtod_out_if.source  o_out
);
    import bcdtod_pkg::*;

    // Clock state and alarm registers.
    t_state  r_state;
    t_state  n_state;
    t_tod    r_alarm;
    t_tod    w_load;
    t_result w_result;
    logic    w_q_ready;
    logic    w_in_accept;
    logic    w_cfg_accept;

    assign i_in.ready   = w_q_ready;
    assign i_cfg.ready  = 1'b1;
    assign w_in_accept  = i_in.valid && w_q_ready;
    assign w_cfg_accept = i_cfg.valid;

    assign w_load.hour   = i_in.load_hour;
    assign w_load.minute = i_in.load_minute;
    assign w_load.second = i_in.load_second;
    assign w_load.tenth  = i_in.load_tenth;

    // All arithmetic for a transaction happens here in one pass.
    bcdtod_step u_step (
        .i_state  (r_state),
        .i_op     (i_in.operation),
        .i_load   (w_load),
        .i_alarm  (r_alarm),
        .o_state  (n_state),
        .o_result (w_result)
    );

    // State moves only when a transaction is taken; the result is pushed then.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.tod.hour   <= HOUR_RESET;
            r_state.tod.minute <= 7'h00;
            r_state.tod.second <= 7'h00;
            r_state.tod.tenth  <= 4'h0;
            r_state.halted     <= 1'b1;
            r_state.match_seen <= 1'b0;
        end else if (w_in_accept) begin
            r_state <= n_state;
        end
    end

    // Alarm register writes; each register keeps only its own width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm <= '0;
        end else if (w_cfg_accept) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_ALARM_HOUR:   r_alarm.hour   <= i_cfg.data;
                CFG_ALARM_MINUTE: r_alarm.minute <= i_cfg.data[6:0];
                CFG_ALARM_SECOND: r_alarm.second <= i_cfg.data[6:0];
                CFG_ALARM_TENTH:  r_alarm.tenth  <= i_cfg.data[3:0];
                default:          r_alarm        <= r_alarm;
            endcase
        end
    end

    bcdtod_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_in_accept),
        .i_data  (w_result),
        .o_ready (w_q_ready),
        .o_out   (o_out)
    );

    // An alarm can only fire on a tick that counted.
    `ASSERT_HOLDS(a_irq_when_running, o_out.valid && o_out.alarm_irq, o_out.running,
        "alarm interrupt on a result from a stopped clock")
    // A tick on a stopped clock leaves the time alone.
    `ASSERT_NEXT(a_stopped_tick_holds,
        w_in_accept && (i_in.operation == OP_TICK) && r_state.halted,
        $stable(r_state.tod), "time changed on a tick while stopped")
    // Match history changes only on a counting tick.
    `ASSERT_NEXT(a_match_history,
        !(w_in_accept && (i_in.operation == OP_TICK) && !r_state.halted),
        $stable(r_state.match_seen), "match history changed outside a running tick")

endmodule

// ----- dv/bcd_time_of_day_clock_alarm_test.sv -----
// Self-checking testbench of the BCD time-of-day clock with 12-hour hours and alarm.
`timescale 1ns / 100ps

module bcd_time_of_day_clock_alarm_test;
    import bcdtod_pkg::*;

    // The run is ended as a failure when a quiet stretch with no transaction
    // on any channel reaches STALL_LIMIT. The longest legal quiet stretch is
    // the deliberate receiver hold-off set by HOLD_CYCLES.
    localparam int unsigned STALL_LIMIT  = 1000;
    localparam int unsigned HOLD_CYCLES  = 60;
    localparam int unsigned MAX_REPORTS  = 200;
    localparam int unsigned PHASE_COUNT  = 8;
    localparam int unsigned PHASE_ITEMS  = 52;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bcdtod_cfg_if cfg_if ();
    bcdtod_in_if  in_if ();
    bcdtod_out_if out_if ();

    bcd_time_of_day_clock_alarm dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the clock: current time, run flag, match history and
    // the alarm registers as the block should hold them.
    t_tod   tod_now;
    t_tod   alarm_time;
    logic   clock_halted;
    logic   alarm_matched;

    // Expected results in the order their input transactions were accepted.
    t_result expected_results[$];

    int unsigned mismatch_count = 0;
    int unsigned result_seq     = 0;
    int unsigned quiet_cycles   = 0;

    // While set, neither the sender nor the receiver idles at random.
    bit          no_idle      = 1'b0;
    // A nonzero value asks the receiver to hold off for that many cycles.
    int unsigned hold_request = 0;
    int unsigned hold_left    = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // One digit step on the low nibble: 9 and 15 wrap to 0 and carry into
    // the high nibble; 10..14 simply count up.
    function automatic logic [7:0] digit_step(input logic [7:0] x);
        if (x[3:0] == 4'h9 || x[3:0] == 4'hF) begin
            return {x[7:4] + 4'd1, 4'h0};
        end
        return {x[7:4], x[3:0] + 4'd1};
    endfunction

    // Advance a time by one tenth of a second. Each stage rolls over to zero
    // only on an exact 9 (tenths) or 59 (seconds, minutes); otherwise it
    // takes a digit step and the carry chain stops there.
    function automatic t_tod tod_plus_tenth(input t_tod t);
        t_tod       r;
        logic [7:0] wide;
        logic [4:0] hr;
        logic       pm;
        r = t;
        if (t.tenth != 4'h9) begin
            wide    = digit_step({4'h0, t.tenth});
            r.tenth = wide[3:0];
        end else begin
            r.tenth = 4'h0;
            if (t.second != 7'h59) begin
                wide     = digit_step({1'b0, t.second});
                r.second = wide[6:0];
            end else begin
                r.second = 7'h00;
                if (t.minute != 7'h59) begin
                    wide     = digit_step({1'b0, t.minute});
                    r.minute = wide[6:0];
                end else begin
                    // Hour rollover keeps only the PM bit and the 5-bit hour.
                    r.minute = 7'h00;
                    pm = t.hour[7];
                    hr = t.hour[4:0];
                    if (hr == 5'h11) begin
                        pm = ~pm;
                    end
                    if (hr == 5'h12) begin
                        hr = 5'h01;
                    end else if (hr == 5'h09) begin
                        hr = 5'h10;
                    end else begin
                        hr = {hr[4], hr[3:0] + 4'd1};
                    end
                    r.hour = {pm, 2'b00, hr};
                end
            end
        end
        return r;
    endfunction

    // Apply one accepted input transaction to the shadow state and return
    // the result that the block must produce for it. Only a tick while
    // running advances the time and touches the match history.
    function automatic t_result clock_step(input t_op op, input t_tod load);
        t_result r;
        logic    hit;
        r.alarm_irq = 1'b0;
        case (op)
            OP_TICK: begin
                if (!clock_halted) begin
                    tod_now       = tod_plus_tenth(tod_now);
                    hit           = (tod_now == alarm_time);
                    r.alarm_irq   = hit && !alarm_matched;
                    alarm_matched = hit;
                end
            end
            OP_LOAD:  tod_now      = load;
            OP_START: clock_halted = 1'b0;
            OP_STOP:  clock_halted = 1'b1;
            default:  clock_halted = clock_halted;
        endcase
        r.tod     = tod_now;
        r.running = !clock_halted;
        return r;
    endfunction

    // Register write as the block should see it: narrow registers drop the
    // upper data bits.
    function automatic void alarm_write(input t_cfg_idx idx, input logic [7:0] data);
        case (idx)
            CFG_ALARM_HOUR:   alarm_time.hour   = data;
            CFG_ALARM_MINUTE: alarm_time.minute = data[6:0];
            CFG_ALARM_SECOND: alarm_time.second = data[6:0];
            CFG_ALARM_TENTH:  alarm_time.tenth  = data[3:0];
            default:          alarm_time        = alarm_time;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Time values for the stimulus
    // ------------------------------------------------------------------

    function automatic t_tod mk_tod(input logic [7:0] h, input logic [6:0] m,
                                    input logic [6:0] s, input logic [3:0] t);
        t_tod r;
        r.hour   = h;
        r.minute = m;
        r.second = s;
        r.tenth  = t;
        return r;
    endfunction

    function automatic logic [7:0] to_bcd(input int unsigned v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    // Any bit pattern at all; used for broken loads and for the payload of
    // transactions that do not use it.
    function automatic t_tod random_bits_tod();
        return mk_tod(8'($urandom), 7'($urandom), 7'($urandom), 4'($urandom));
    endfunction

    // A proper 12-hour BCD time. Near a rollover the minutes and seconds sit
    // at 59 so that a few ticks carry into the hours.
    function automatic t_tod random_clock_time(input bit near_rollover);
        logic [7:0] h;
        logic [7:0] m;
        logic [7:0] s;
        h = to_bcd($urandom_range(1, 12));
        m = near_rollover ? 8'h59 : to_bcd($urandom_range(0, 59));
        s = near_rollover ? 8'h59 : to_bcd($urandom_range(0, 59));
        return mk_tod({1'($urandom_range(1)), 2'b00, h[4:0]}, m[6:0], s[6:0],
                      4'($urandom_range(0, 9)));
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Offer one input transaction and wait until it is taken. Valid is left
    // high afterwards; the next call either replaces the payload or lowers
    // valid for a random gap, so valid changes at most once per falling edge.
    task automatic send_item(input t_op op, input t_tod load);
        int unsigned gap;
        if (!no_idle && $urandom_range(99) < 8) begin
            gap = $urandom_range(1, 4);
            @(negedge i_clk);
            in_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_if.valid       <= 1'b1;
        in_if.operation   <= op;
        in_if.load_hour   <= load.hour;
        in_if.load_minute <= load.minute;
        in_if.load_second <= load.second;
        in_if.load_tenth  <= load.tenth;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        expected_results.push_back(clock_step(op, load));
    endtask

    // Operations that ignore the payload still get random payload bits.
    task automatic send_op(input t_op op);
        send_item(op, random_bits_tod());
    endtask

    task automatic send_load(input t_tod load);
        send_item(OP_LOAD, load);
    endtask

    // Stop offering and wait until every expected result has come back, then
    // idle on before returning, covering the result register and the skid stage.
    task automatic wait_drained();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_alarm_reg(input t_cfg_idx idx, input logic [7:0] data);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        alarm_write(idx, data);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Alarm registers are only written once the block has gone idle.
    task automatic set_alarm(input logic [7:0] h, input logic [7:0] m,
                             input logic [7:0] s, input logic [7:0] t);
        wait_drained();
        write_alarm_reg(CFG_ALARM_HOUR, h);
        write_alarm_reg(CFG_ALARM_MINUTE, m);
        write_alarm_reg(CFG_ALARM_SECOND, s);
        write_alarm_reg(CFG_ALARM_TENTH, t);
    endtask

    // ------------------------------------------------------------------
    // Receiver, checker and watchdog
    // ------------------------------------------------------------------

    // The receiver stalls at random about 8 times in a hundred, and for a
    // long stretch when a test asks for it; the hold-off is counted here.
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left    = hold_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= no_idle || ($urandom_range(99) >= 8);
        end
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    // Every result transaction is matched against the oldest expectation;
    // all differing fields of one result go on one line.
    always @(posedge i_clk) begin
        t_result want;
        string   diffs;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing pending",
                                          result_seq));
            end else begin
                want  = expected_results.pop_front();
                diffs = "";
                if (out_if.time_hour !== want.tod.hour) begin
                    diffs = {diffs, $sformatf(" hour %02h/%02h", out_if.time_hour,
                                              want.tod.hour)};
                end
                if (out_if.time_minute !== want.tod.minute) begin
                    diffs = {diffs, $sformatf(" minute %02h/%02h", out_if.time_minute,
                                              want.tod.minute)};
                end
                if (out_if.time_second !== want.tod.second) begin
                    diffs = {diffs, $sformatf(" second %02h/%02h", out_if.time_second,
                                              want.tod.second)};
                end
                if (out_if.time_tenth !== want.tod.tenth) begin
                    diffs = {diffs, $sformatf(" tenth %h/%h", out_if.time_tenth,
                                              want.tod.tenth)};
                end
                if (out_if.alarm_irq !== want.alarm_irq) begin
                    diffs = {diffs, $sformatf(" alarm_irq %b/%b", out_if.alarm_irq,
                                              want.alarm_irq)};
                end
                if (out_if.running !== want.running) begin
                    diffs = {diffs, $sformatf(" running %b/%b", out_if.running,
                                              want.running)};
                end
                if (diffs != "") begin
                    report_mismatch($sformatf("result %0d (got/expected):%s",
                                              result_seq, diffs));
                end
            end
            result_seq++;
        end
    end

    // A hung block shows up as a long run of cycles with no transaction.
    always @(posedge i_clk) begin
        if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
            (out_if.valid === 1'b1 && out_if.ready === 1'b1) ||
            (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset the clock is stopped at 01:00:00.0 AM, so a tick leaves
    // the time alone and raises no interrupt.
    task automatic test_reset_state();
        send_op(OP_TICK);
        send_op(OP_STOP);
    endtask

    // Loads take every bit as given, the extremes included, and a tick while
    // stopped does not move the loaded time.
    task automatic test_load_extremes();
        send_load(mk_tod(8'hFF, 7'h7F, 7'h7F, 4'hF));
        send_load(mk_tod(8'h00, 7'h00, 7'h00, 4'h0));
        send_op(OP_TICK);
    endtask

    // Carries through every stage, the hour rollovers, and the handling of
    // digits that are not BCD.
    task automatic test_rollovers();
        send_op(OP_START);
        // 11 AM to 12 PM flips the PM bit.
        send_load(mk_tod(8'h11, 7'h59, 7'h59, 4'h9));
        send_op(OP_TICK);
        // 12 PM goes to 1 PM with the PM bit kept.
        send_load(mk_tod(8'h92, 7'h59, 7'h59, 4'h9));
        send_op(OP_TICK);
        // 9 goes to 10 through the high hour digit.
        send_load(mk_tod(8'h09, 7'h59, 7'h59, 4'h9));
        send_op(OP_TICK);
        // A garbage hour: bits 6..5 are dropped and the low nibble wraps.
        send_load(mk_tod(8'hFF, 7'h59, 7'h59, 4'h9));
        send_op(OP_TICK);
        // Tenths of 10 count up, tenths of 15 wrap to 0 without a carry.
        send_load(mk_tod(8'h05, 7'h30, 7'h30, 4'hA));
        send_op(OP_TICK);
        send_load(mk_tod(8'h05, 7'h30, 7'h30, 4'hF));
        send_op(OP_TICK);
        // Seconds of 7F wrap to 00 within seven bits.
        send_load(mk_tod(8'h05, 7'h30, 7'h7F, 4'h9));
        send_op(OP_TICK);
    endtask

    // The interrupt fires only where a match begins. A load does not clear
    // the match history, so reaching the alarm again straight after a match
    // stays silent, while a tick that breaks the match re-arms it.
    task automatic test_alarm_edge();
        set_alarm(8'h81, 8'h00, 8'h00, 8'h00);
        send_load(mk_tod(8'h92, 7'h59, 7'h59, 4'h9));
        send_op(OP_TICK);
        send_load(mk_tod(8'h92, 7'h59, 7'h59, 4'h9));
        send_op(OP_TICK);
        send_op(OP_TICK);
        send_load(mk_tod(8'h92, 7'h59, 7'h59, 4'h9));
        send_op(OP_TICK);
    endtask

    // Random phases. Each phase sets the alarm while idle, starts the clock
    // from a proper time and then mostly ticks, so that the carry chain and
    // the alarm compare are reached; replays of the start time revisit the
    // alarm, and broken loads, stops and starts make up the noise.
    task automatic test_random_phases();
        t_tod        base;
        t_tod        target;
        int unsigned roll;
        for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
            base   = random_clock_time($urandom_range(1));
            target = base;
            repeat ($urandom_range(1, 30)) target = tod_plus_tenth(target);
            if (p == 0) begin
                set_alarm(8'h00, 8'h00, 8'h00, 8'h00);
            end else if (p == 1) begin
                set_alarm(8'hFF, 8'hFF, 8'hFF, 8'hFF);
            end else begin
                set_alarm(target.hour, {1'($urandom_range(1)), target.minute},
                          {1'($urandom_range(1)), target.second},
                          {4'($urandom), target.tenth});
            end
            // One phase runs without any idling on either side.
            no_idle = (p == 3);
            send_op(OP_START);
            send_load(base);
            for (int unsigned n = 2; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(99);
                if (roll < 80) begin
                    send_op(OP_TICK);
                end else if (roll < 86) begin
                    send_load(base);
                end else if (roll < 91) begin
                    send_load(random_bits_tod());
                end else if (roll < 95) begin
                    send_op(OP_STOP);
                end else begin
                    send_op(OP_START);
                end
            end
            no_idle = 1'b0;
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering ticks back to back, so the result stages fill and the input
    // is stalled; then the sender pauses until everything has come back.
    task automatic test_backpressure();
        t_tod base;
        base = random_clock_time(1'b1);
        set_alarm(8'h12, 8'h00, 8'h00, 8'h05);
        send_op(OP_START);
        send_load(base);
        no_idle      = 1'b1;
        hold_request = HOLD_CYCLES;
        repeat (40) send_op(OP_TICK);
        no_idle = 1'b0;
        wait_drained();
    endtask

    initial begin
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.operation    = OP_TICK;
        in_if.load_hour    = '0;
        in_if.load_minute  = '0;
        in_if.load_second  = '0;
        in_if.load_tenth   = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = CFG_ALARM_HOUR;
        cfg_if.data        = '0;
        out_if.ready       = 1'b0;

        // Reset state of the shadow copy.
        tod_now       = mk_tod(8'h01, 7'h00, 7'h00, 4'h0);
        alarm_time    = mk_tod(8'h00, 7'h00, 7'h00, 4'h0);
        clock_halted  = 1'b1;
        alarm_matched = 1'b0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_load_extremes();
        test_rollovers();
        test_alarm_edge();
        test_random_phases();
        test_backpressure();

        wait_drained();
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/bcdtod_pkg.sv
sv/bcdtod_ifs.sv
sv/bcdtod_step.sv
sv/bcdtod_outq.sv
sv/bcd_time_of_day_clock_alarm.sv
dv/bcd_time_of_day_clock_alarm_test.sv
